### rtl/td0_value_table_update_defines.svh
// Assertion helpers for the TD(0) value table block.
`ifndef TD0_VALUE_TABLE_UPDATE_DEFINES_SVH
`define TD0_VALUE_TABLE_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TD0_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("td0_value_table_update: assertion failed");

// Next-cycle implication, disabled during reset.
`define TD0_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("td0_value_table_update: assertion failed");

`endif

### rtl/td0_pkg.sv
package td0_pkg;

	localparam int VAL_W      = 32;
	localparam int COEF_W     = 17;
	localparam int COORD_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_W     = 16;
	localparam int HALF_Q16   = 32768;

	// gamma * v: 18-bit signed coefficient times 32-bit value
	localparam int PROD_G_W = COEF_W + 1 + VAL_W;
	localparam int GV_W     = PROD_G_W - FRAC_W;
	localparam int DELTA_W  = 34;
	localparam int PROD_A_W = COEF_W + 1 + DELTA_W;
	localparam int STEP_W   = PROD_A_W - FRAC_W;
	localparam int NV_W     = STEP_W + 1;

	localparam logic [COEF_W-1:0] ONE_Q16        = 17'd65536;
	localparam logic [COEF_W-1:0] LEARN_RATE_RST = 17'd6554;
	localparam logic [COEF_W-1:0] DISCOUNT_RST   = 17'd65536;
	localparam logic [VAL_W-1:0]  STEP_REWARD_RST = 32'd65536;

	localparam logic signed [PROD_G_W-1:0] G_HALF = PROD_G_W'(HALF_Q16);
	localparam logic signed [PROD_A_W-1:0] A_HALF = PROD_A_W'(HALF_Q16);

	localparam logic signed [NV_W-1:0]  NV_MAX  = NV_W'(64'sd2147483647);
	localparam logic signed [NV_W-1:0]  NV_MIN  = NV_W'(-64'sd2147483648);
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARN_RATE  = 2'd0,
		CFG_DISCOUNT    = 2'd1,
		CFG_STEP_REWARD = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DELTA,
		ST_SCALE,
		ST_WRITE
	} state_t;

endpackage

### rtl/td0_req_if.sv
interface td0_req_if;
	import td0_pkg::*;

	logic               valid;
	logic               ready;
	logic               mode;
	logic [COORD_W-1:0] cur_row;
	logic [COORD_W-1:0] cur_col;
	logic [COORD_W-1:0] next_row;
	logic [COORD_W-1:0] next_col;
	logic               final_step;

	modport source (output valid, mode, cur_row, cur_col, next_row, next_col, final_step,
		input ready);
	modport sink (input valid, mode, cur_row, cur_col, next_row, next_col, final_step,
		output ready);
endinterface

### rtl/td0_rsp_if.sv
interface td0_rsp_if;
	import td0_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] cell_value;
	logic                    saturated;

	modport source (output valid, cell_value, saturated, input ready);
	modport sink (input valid, cell_value, saturated, output ready);
endinterface

### rtl/td0_value_table_update.sv
// TD(0) value table over a GRID_SIDE x GRID_SIDE grid, signed Q16.16 values.
// req (sink): one request per visited transition, accepted on valid && ready.
//   mode 0 applies v[cur] += alpha*(reward + gamma*v[next] - v[cur]),
//   next value taken as zero when final_step is set; mode 1 reads v[cur].
// rsp (source): one result per request, the new or read cell value and a
//   flag set when the update clipped to the 32-bit range.
// cfg: write enable, index and data; 0 learn_rate, 1 discount (both clamped
//   to 1.0), 2 step_reward. Other indexes are ignored. Write only while idle.
// Flow: an update request passes through the gamma product, delta, alpha
//   product and write back steps before rsp.valid rises; a read goes straight
//   to the output register. One request is in flight at a time, so a new
//   request is taken only once the last one's result has been loaded.
// Reset: the table is cleared by a sweep over all GRID_SIDE*GRID_SIDE entries,
//   one entry per cycle; req.ready stays low until it ends. Config registers
//   return to alpha 0.1, gamma 1.0, reward 1.0 at once.
// Stall: the result sits in an output register; a new request is accepted
//   while it waits, and the next result holds in the last stage until taken.
module td0_value_table_update #(
	parameter int GRID_SIDE = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [td0_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [td0_pkg::CFG_DATA_W-1:0]      cfg_data,
	td0_req_if.sink                             req,
	td0_rsp_if.source                           rsp
);
	import td0_pkg::*;
	`include "td0_value_table_update_defines.svh"

	localparam int CELLS  = GRID_SIDE * GRID_SIDE;
	localparam int CELL_W = $clog2(CELLS);

	function automatic logic [CELL_W-1:0] cell_at(logic [COORD_W-1:0] row,
			logic [COORD_W-1:0] col);
		int r;
		int c;
		r = int'(row);
		c = int'(col);
		if (r >= GRID_SIDE) begin
			r = r - GRID_SIDE;
		end
		if (c >= GRID_SIDE) begin
			c = c - GRID_SIDE;
		end
		return CELL_W'(r * GRID_SIDE + c);
	endfunction

	function automatic logic [COEF_W-1:0] clamp_one(logic [COEF_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	state_t state_q, state_d;

	logic [COEF_W-1:0]       learn_rate_q;
	logic [COEF_W-1:0]       discount_q;
	logic signed [VAL_W-1:0] step_reward_q;

	logic [VAL_W-1:0] mem [CELLS];
	logic             mem_we;
	logic [CELL_W-1:0] mem_wa;
	logic [VAL_W-1:0]  mem_wd;
	logic [CELL_W-1:0] clr_cnt_q;

	logic                    req_ready;
	logic                    accept;
	logic                    out_load;
	logic                    out_free;
	logic                    out_v_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    out_sat_q;
	logic signed [VAL_W-1:0] out_val_d;
	logic                    out_sat_d;

	logic              mode_q;
	logic              final_q;
	logic [CELL_W-1:0] cur_idx_q;
	logic signed [VAL_W-1:0] rd_cur_q;
	logic signed [VAL_W-1:0] rd_nxt_q;

	logic signed [PROD_G_W-1:0] gprod_s1;
	logic signed [PROD_G_W-1:0] gsum;
	logic signed [GV_W-1:0]     gv;
	logic signed [DELTA_W-1:0]  delta_d;
	logic signed [DELTA_W-1:0]  delta_s2;
	logic signed [PROD_A_W-1:0] aprod_s3;
	logic signed [PROD_A_W-1:0] asum;
	logic signed [STEP_W-1:0]   step;
	logic signed [NV_W-1:0]     nv;
	logic signed [VAL_W-1:0]    nv_sat;
	logic                       nv_clip;

	assign accept   = req.valid && req_ready;
	assign out_free = !out_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q  <= LEARN_RATE_RST;
			discount_q    <= DISCOUNT_RST;
			step_reward_q <= STEP_REWARD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_LEARN_RATE:  learn_rate_q  <= clamp_one(cfg_data[COEF_W-1:0]);
				CFG_DISCOUNT:    discount_q    <= clamp_one(cfg_data[COEF_W-1:0]);
				CFG_STEP_REWARD: step_reward_q <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_cnt_q == CELL_W'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (mode_q == MODE_READ) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_WRITE;
			ST_WRITE: begin
				if (out_free) begin
					mem_we   = 1'b1;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// request capture and table read
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= req.mode;
			final_q   <= req.final_step;
			cur_idx_q <= cell_at(req.cur_row, req.cur_col);
			rd_cur_q  <= mem[cell_at(req.cur_row, req.cur_col)];
			rd_nxt_q  <= mem[cell_at(req.next_row, req.next_col)];
		end
	end

	assign mem_wa = (state_q == ST_CLEAR) ? clr_cnt_q : cur_idx_q;
	assign mem_wd = (state_q == ST_CLEAR) ? '0 : nv_sat;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// update datapath
	assign gsum    = gprod_s1 + G_HALF;
	assign gv      = gsum[PROD_G_W-1:FRAC_W];
	assign delta_d = DELTA_W'(step_reward_q) + DELTA_W'(gv) - DELTA_W'(rd_cur_q);
	assign asum    = aprod_s3 + A_HALF;
	assign step    = asum[PROD_A_W-1:FRAC_W];
	assign nv      = NV_W'(rd_cur_q) + NV_W'(step);

	always_comb begin
		nv_clip = 1'b1;
		if (nv > NV_MAX) begin
			nv_sat = VAL_MAX;
		end else if (nv < NV_MIN) begin
			nv_sat = VAL_MIN;
		end else begin
			nv_sat  = nv[VAL_W-1:0];
			nv_clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			if (final_q) begin
				gprod_s1 <= '0;
			end else begin
				gprod_s1 <= $signed({1'b0, discount_q}) * rd_nxt_q;
			end
		end
		if (state_q == ST_DELTA) begin
			delta_s2 <= delta_d;
		end
		if (state_q == ST_SCALE) begin
			aprod_s3 <= $signed({1'b0, learn_rate_q}) * delta_s2;
		end
	end

	assign out_val_d = (state_q == ST_READ) ? rd_cur_q : nv_sat;
	assign out_sat_d = (state_q == ST_READ) ? 1'b0 : nv_clip;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q <= out_val_d;
			out_sat_q <= out_sat_d;
		end
	end

	assign req.ready      = req_ready;
	assign rsp.valid      = out_v_q;
	assign rsp.cell_value = out_val_q;
	assign rsp.saturated  = out_sat_q;

	`TD0_ASSERT_IMP(a_no_req_in_clear, state_q == ST_CLEAR, !req.ready)
	`TD0_ASSERT_NXT(a_accept_leaves_idle, req.valid && req.ready, state_q == ST_READ)
	`TD0_ASSERT_IMP(a_load_when_free, out_load, !out_v_q || rsp.ready)
	`TD0_ASSERT_IMP(a_write_only_wb, mem_we && state_q != ST_CLEAR, state_q == ST_WRITE)
	`TD0_ASSERT_IMP(a_sat_at_limit, out_v_q && out_sat_q, out_val_q == VAL_MAX || out_val_q == VAL_MIN)

endmodule

### bench/td0_value_table_update_test.sv
`timescale 1ns / 100ps

module td0_value_table_update_test;
	import td0_pkg::*;

	localparam int GRID_SIDE   = 4;
	localparam int CELLS       = GRID_SIDE * GRID_SIDE;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 158;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic               mode;
		logic [COORD_W-1:0] cur_row;
		logic [COORD_W-1:0] cur_col;
		logic [COORD_W-1:0] next_row;
		logic [COORD_W-1:0] next_col;
		logic               final_step;
	} request_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] cell_value;
		logic                    saturated;
	} cell_result_t;

	localparam int REQ_W = $bits(request_t);

	class td0_value_tracker;
		logic signed [VAL_W-1:0] cells [CELLS];
		logic [COEF_W-1:0]       learn_rate;
		logic [COEF_W-1:0]       discount;
		logic signed [VAL_W-1:0] step_reward;
		cell_result_t            awaited [$];
		int                      errors;
		int                      updates;
		int                      reads;
		int                      clipped;

		function new();
			foreach (cells[i])
				cells[i] = '0;
			learn_rate  = LEARN_RATE_RST;
			discount    = DISCOUNT_RST;
			step_reward = STEP_REWARD_RST;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LEARN_RATE:  learn_rate = data[COEF_W-1:0];
				CFG_DISCOUNT:    discount = data[COEF_W-1:0];
				CFG_STEP_REWARD: step_reward = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_request(request_t r);
			cell_result_t res;
			int           cur;
			int           nxt;
			longint       alpha;
			longint       gamma;
			longint       cur_v;
			longint       gv;
			longint       delta;
			longint       stride;
			longint       nv;
			cur   = r.cur_row * GRID_SIDE + r.cur_col;
			nxt   = r.next_row * GRID_SIDE + r.next_col;
			cur_v = cells[cur];
			res.cell_value = cells[cur];
			res.saturated  = 1'b0;
			if (r.mode == MODE_READ) begin
				reads++;
			end else begin
				alpha  = (learn_rate > ONE_Q16) ? ONE_Q16 : learn_rate;
				gamma  = (discount > ONE_Q16) ? ONE_Q16 : discount;
				gv     = r.final_step ? 0 : (gamma * longint'(cells[nxt]) + HALF_Q16) >>> FRAC_W;
				delta  = longint'(step_reward) + gv - cur_v;
				stride = (alpha * delta + HALF_Q16) >>> FRAC_W;
				nv     = cur_v + stride;
				if (nv > longint'(VAL_MAX)) begin
					nv = VAL_MAX;
					res.saturated = 1'b1;
				end else if (nv < longint'(VAL_MIN)) begin
					nv = VAL_MIN;
					res.saturated = 1'b1;
				end
				cells[cur]     = nv[VAL_W-1:0];
				res.cell_value = nv[VAL_W-1:0];
				updates++;
				if (res.saturated)
					clipped++;
			end
			awaited.insert(awaited.size(), res);
		endfunction

		function void check_result(logic signed [VAL_W-1:0] value, logic sat);
			cell_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$error("cell_value: no request outstanding, got %0d", value);
				return;
			end
			want = awaited.pop_front();
			if (value !== want.cell_value) begin
				errors++;
				$error("cell_value: expected %0d, got %0d", want.cell_value, value);
			end
			if (sat !== want.saturated) begin
				errors++;
				$error("saturated: expected %0b, got %0b", want.saturated, sat);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	td0_req_if req_ch ();
	td0_rsp_if rsp_ch ();

	td0_value_table_update #(
		.GRID_SIDE(GRID_SIDE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	td0_value_tracker tracker = new();

	bit             steady;
	bit             hold_off;
	int             settings;
	logic [COORD_W-1:0] walk_row;
	logic [COORD_W-1:0] walk_col;

	always #2 clk = ~clk;

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			tracker.note_request({req_ch.mode, req_ch.cur_row, req_ch.cur_col,
				req_ch.next_row, req_ch.next_col, req_ch.final_step});
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_result(rsp_ch.cell_value, rsp_ch.saturated);
	end

	// receiver: random back-pressure, one long hold-off when asked
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			rsp_ch.ready <= arst_n && (steady || $urandom_range(99) >= 26);
		end
	end

	function automatic request_t make_request(logic mode, int cr, int cc, int nr, int nc,
		logic fin);
		request_t r;
		r.mode       = mode;
		r.cur_row    = COORD_W'(cr);
		r.cur_col    = COORD_W'(cc);
		r.next_row   = COORD_W'(nr);
		r.next_col   = COORD_W'(nc);
		r.final_step = fin;
		return r;
	endfunction

	task automatic send_request(input request_t r);
		if (!steady && $urandom_range(99) < 26) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= r.mode;
		req_ch.cur_row    <= r.cur_row;
		req_ch.cur_col    <= r.cur_col;
		req_ch.next_row   <= r.next_row;
		req_ch.next_col   <= r.next_col;
		req_ch.final_step <= r.final_step;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		tracker.set_register(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] lr,
		input logic [CFG_DATA_W-1:0] dc, input logic [CFG_DATA_W-1:0] rw);
		drain();
		write_register(CFG_UNUSED, $urandom);
		write_register(CFG_LEARN_RATE, lr);
		write_register(CFG_DISCOUNT, dc);
		write_register(CFG_STEP_REWARD, rw);
		settings++;
	endtask

	task automatic random_settings();
		logic [CFG_DATA_W-1:0] lr;
		logic [CFG_DATA_W-1:0] dc;
		logic [CFG_DATA_W-1:0] rw;
		lr = $urandom;
		dc = $urandom;
		case ($urandom_range(4))
			0: lr[COEF_W-1:0] = '0;
			1: lr[COEF_W-1:0] = 17'd1;
			2: lr[COEF_W-1:0] = ONE_Q16;
			3: lr[COEF_W-1:0] = '1;
			default: lr[COEF_W-1:0] = COEF_W'($urandom_range(0, ONE_Q16));
		endcase
		case ($urandom_range(4))
			0: dc[COEF_W-1:0] = '0;
			1: dc[COEF_W-1:0] = ONE_Q16;
			2: dc[COEF_W-1:0] = '1;
			default: dc[COEF_W-1:0] = COEF_W'($urandom_range(0, ONE_Q16));
		endcase
		case ($urandom_range(3))
			0: rw = VAL_MAX;
			1: rw = VAL_MIN;
			2: rw = $urandom_range(0, 262144) - 131072;
			default: rw = $urandom;
		endcase
		apply_settings(lr, dc, rw);
	endtask

	// episode walks over neighboring cells, with some noise requests mixed in
	task automatic run_phase(input int count);
		request_t r;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 20) begin
				r = REQ_W'($urandom);
			end else begin
				r.mode     = ($urandom_range(99) < 20) ? MODE_READ : MODE_UPDATE;
				r.cur_row  = walk_row;
				r.cur_col  = walk_col;
				r.next_row = walk_row;
				r.next_col = walk_col;
				if ($urandom_range(1))
					r.next_row = walk_row + ($urandom_range(1) ? 2'd1 : 2'd3);
				else
					r.next_col = walk_col + ($urandom_range(1) ? 2'd1 : 2'd3);
				r.final_step = $urandom_range(99) < 15;
				if (r.mode == MODE_UPDATE) begin
					if (r.final_step) begin
						walk_row = COORD_W'($urandom);
						walk_col = COORD_W'($urandom);
					end else begin
						walk_row = r.next_row;
						walk_col = r.next_col;
					end
				end
			end
			send_request(r);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.mode       <= MODE_UPDATE;
		req_ch.cur_row    <= '0;
		req_ch.cur_col    <= '0;
		req_ch.next_row   <= '0;
		req_ch.next_col   <= '0;
		req_ch.final_step <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_idx  <= CFG_LEARN_RATE;
		cfg_data <= '0;
		walk_row = '0;
		walk_col = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);

		// default coefficients straight out of reset
		send_request(make_request(MODE_READ, 0, 0, 0, 0, 1'b0));
		send_request(make_request(MODE_UPDATE, 0, 0, 3, 3, 1'b0));
		send_request(make_request(MODE_UPDATE, 3, 3, 0, 0, 1'b1));
		send_request(make_request(MODE_UPDATE, 0, 0, 3, 3, 1'b0));
		send_request(make_request(MODE_READ, 3, 3, 1, 1, 1'b1));
		send_request(make_request(MODE_UPDATE, 3, 3, 3, 3, 1'b0));

		// full step, top reward: clip high
		apply_settings(32'd65536, 32'd65536, 32'h7fff_ffff);
		send_request(make_request(MODE_UPDATE, 1, 2, 0, 0, 1'b1));
		send_request(make_request(MODE_UPDATE, 2, 1, 1, 2, 1'b0));
		send_request(make_request(MODE_READ, 2, 1, 0, 0, 1'b0));
		send_request(make_request(MODE_UPDATE, 1, 2, 1, 2, 1'b0));

		// bottom reward: clip low
		apply_settings(32'd65536, 32'd65536, 32'h8000_0000);
		send_request(make_request(MODE_UPDATE, 3, 0, 2, 2, 1'b1));
		send_request(make_request(MODE_UPDATE, 0, 3, 3, 0, 1'b0));
		send_request(make_request(MODE_READ, 0, 3, 3, 3, 1'b1));

		// learn rate above 1.0 clamps; stray high data bits
		apply_settings(32'hffff_ffff, 32'hfffe_0001, 32'h0001_8000);
		send_request(make_request(MODE_UPDATE, 2, 2, 0, 0, 1'b0));
		send_request(make_request(MODE_UPDATE, 2, 2, 1, 2, 1'b0));

		apply_settings(32'd1, 32'd0, 32'hffff_7fff);
		send_request(make_request(MODE_UPDATE, 1, 1, 2, 1, 1'b0));
		send_request(make_request(MODE_UPDATE, 0, 0, 0, 0, 1'b1));
		send_request(make_request(MODE_READ, 1, 1, 0, 0, 1'b0));

		// halves for rounding
		apply_settings(32'h0000_8000, 32'h0000_8000, 32'hffff_8000);
		send_request(make_request(MODE_UPDATE, 3, 3, 0, 0, 1'b0));
		send_request(make_request(MODE_UPDATE, 2, 1, 3, 0, 1'b0));
		send_request(make_request(MODE_UPDATE, 3, 0, 2, 1, 1'b0));
		send_request(make_request(MODE_READ, 3, 2, 0, 0, 1'b0));

		for (int phase = 0; phase < PHASES; phase++) begin
			random_settings();
			if (phase == 2)
				hold_off = 1'b1;
			steady = (phase == 5);
			run_phase(PHASE_ITEMS);
			steady = 1'b0;
		end

		drain();
		repeat (12) @(posedge clk);
		$display("Covered %0d updates (%0d clipped) and %0d reads over %0d register settings.",
			tracker.updates, tracker.clipped, tracker.reads, settings);
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
